@@ src/mrfb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfb_pkg: shared types and CRC helper for the Modbus RTU frame builder
// Holds the CRC-16/MODBUS constants, the body-count limits, the byte fold
// function and the request struct passed from the input stage.
// ----------------------------------------------------------------------------
package mrfb_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start value
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Body counter is 9 bits wide and saturates at its top value
    localparam int unsigned COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Default body byte limit
    localparam int unsigned MAX_BODY_DEF = 254;

    // Sequencer phase codes for the appended CRC bytes
    localparam int unsigned PHASE_W  = 2;
    localparam logic [PHASE_W-1:0] PH_BODY = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LO   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HI   = 2'd2;

    // One accepted input request
    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } body_req_t;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

@@ src/mrfb_in_stage.sv @@
// ----------------------------------------------------------------------------
// mrfb_in_stage: input register of the frame builder
// Captures one body byte request and holds it until the framer takes it.
// Ready stays high whenever the register is empty or being drained.
// ----------------------------------------------------------------------------
module mrfb_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] body_byte
    input  logic                s_tlast,   // end_of_body
    output logic                req_valid,
    output mrfb_pkg::body_req_t req,
    input  logic                req_take
);
    import mrfb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    body_req_t item_reg;
    logic      accept;

    // Free when empty or when the held request leaves this cycle
    assign s_tready = !valid_reg || req_take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (req_take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.body_byte   <= s_tdata;
            item_reg.end_of_body <= s_tlast;
        end
    end

    assign req_valid = valid_reg;
    assign req       = item_reg;

endmodule

@@ src/mrfb_framer.sv @@
// ----------------------------------------------------------------------------
// mrfb_framer: CRC, body count and output register
// Passes each body byte on while folding it into the CRC. After the final
// body byte it sends the CRC low byte, then the high byte with frame end.
// ----------------------------------------------------------------------------
module mrfb_framer #(
    parameter int unsigned MAX_BODY = mrfb_pkg::MAX_BODY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  mrfb_pkg::body_req_t req,
    output logic                req_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] frame_byte
    output logic [1:0]          m_tuser,   // [0] is_crc, [1] too_long
    output logic                m_tlast    // frame_end
);
    import mrfb_pkg::*;

    localparam logic [COUNT_W-1:0] MaxBodyW = COUNT_W'(MAX_BODY);

    logic [15:0]         crc_reg, crc_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [15:0]         crc_out_reg, crc_out_next;
    logic                long_reg, long_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_crc_reg, out_crc_next;
    logic                out_end_reg, out_end_next;
    logic                out_long_reg, out_long_next;

    logic                out_free;
    logic [COUNT_W-1:0]  count_inc;
    logic [15:0]         crc_fold_val;
    logic                long_flag;

    assign out_free     = !out_valid_reg || m_tready;
    assign count_inc    = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign long_flag    = count_inc > MaxBodyW;
    assign crc_fold_val = crc_fold(crc_reg, req.body_byte);

    // Body bytes move only when no CRC byte is pending
    assign req_take = req_valid && out_free && (phase_reg == PH_BODY);

    // Next-state logic: CRC bytes first, then body bytes
    always_comb
    begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        crc_out_next   = crc_out_reg;
        long_next      = long_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_crc_next   = out_crc_reg;
        out_end_next   = out_end_reg;
        out_long_next  = out_long_reg;

        if (out_free)
        begin
            unique case (phase_reg)
                PH_LO:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_out_reg[7:0];
                    out_crc_next   = 1'b1;
                    out_end_next   = 1'b0;
                    out_long_next  = long_reg;
                    phase_next     = PH_HI;
                end
                PH_HI:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_out_reg[15:8];
                    out_crc_next   = 1'b1;
                    out_end_next   = 1'b1;
                    out_long_next  = long_reg;
                    phase_next     = PH_BODY;
                end
                default:
                begin
                    if (req_valid)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = req.body_byte;
                        out_crc_next   = 1'b0;
                        out_end_next   = 1'b0;
                        out_long_next  = long_flag;
                        if (req.end_of_body)
                        begin
                            crc_out_next = crc_fold_val;
                            long_next    = long_flag;
                            crc_next     = CRC_INIT;
                            count_next   = '0;
                            phase_next   = PH_LO;
                        end
                        else
                        begin
                            crc_next   = crc_fold_val;
                            count_next = count_inc;
                        end
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            count_reg     <= '0;
            phase_reg     <= PH_BODY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        crc_out_reg  <= crc_out_next;
        long_reg     <= long_next;
        out_byte_reg <= out_byte_next;
        out_crc_reg  <= out_crc_next;
        out_end_reg  <= out_end_next;
        out_long_reg <= out_long_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_long_reg, out_crc_reg};
    assign m_tlast  = out_end_reg;

`ifndef NO_ASSERTIONS
    // Frame end only ever marks a CRC byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> out_crc_reg)
        else $error("frame end on a non-CRC byte");

    // While CRC bytes are pending, the CRC and count sit at their start values
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> (crc_reg == CRC_INIT && count_reg == '0))
        else $error("CRC or count not cleared after final body byte");

    // No body request is taken while CRC bytes are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> !req_take)
        else $error("body byte taken during CRC output");

    // Sending the low CRC byte is always followed by the high one
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LO && out_free) |=> (phase_reg == PH_HI && out_valid_reg))
        else $error("CRC high byte does not follow low byte");
`endif

endmodule

@@ src/modbus_rtu_frame_builder.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_frame_builder: Modbus RTU frame body to wire bytes with CRC
// Input stream: one body byte per request (address, function code, data),
// tlast on the final body byte. Output stream: every body byte passed on,
// then the CRC-16/MODBUS low byte and high byte, tlast on the high byte.
// tuser[0] marks CRC bytes; tuser[1] flags a body longer than MAX_BODY.
// Path: an accepted body byte waits in the input register, then moves into
// the framer's single output register once that register is free.
// Throughput: one body byte per cycle while the receiver does not stall; after
// the final body byte none is taken until both CRC bytes enter the output register.
// Reset clears the CRC to all ones, the body count to zero and empties both
// the input and output registers. A stalled receiver holds the output byte;
// the input register still takes one more request before tready drops.
// After the final body byte the CRC and count return to their start values.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_builder #(
    parameter int unsigned MAX_BODY = mrfb_pkg::MAX_BODY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] body_byte
    input  logic       s_tlast,   // end_of_body
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] frame_byte
    output logic [1:0] m_tuser,   // [0] is_crc, [1] too_long
    output logic       m_tlast    // frame_end
);
    import mrfb_pkg::*;

    logic      req_valid;
    logic      req_take;
    body_req_t req;

    // Input register
    mrfb_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .req_valid(req_valid),
        .req      (req),
        .req_take (req_take)
    );

    // CRC, count and output register
    mrfb_framer #(
        .MAX_BODY(MAX_BODY)
    ) u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req      (req),
        .req_take (req_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for modbus_rtu_frame_builder
// Sends whole Modbus RTU frame bodies, one byte per request, and checks every
// wire byte against a local CRC-16/MODBUS framer model: body bytes pass
// through, then the CRC low and high bytes follow. It also checks the overlong
// flag and the body count saturating at its top value. The sender idles and
// the receiver stalls at random in several phases, and one long receiver
// hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

    import mrfb_pkg::*;

    localparam int unsigned HOLD_CYCLES = 300;

    // One byte on the wire, fields in check order
    typedef struct packed {
        logic [7:0] data;
        logic       is_crc;
        logic       frame_end;
        logic       too_long;
    } wire_byte_t;

    // Framer model plus the queue of wire bytes still due
    class frame_scoreboard;
        logic [15:0]  crc_acc;
        int unsigned  body_seen;
        wire_byte_t   pending_bytes[$];
        int unsigned  mismatches;

        function new();
            crc_acc    = CRC_INIT;
            body_seen  = 0;
            mismatches = 0;
        endfunction

        // Accepted body byte: predict its wire bytes
        function void note_body(logic [7:0] b, logic last);
            logic       flag;
            wire_byte_t item;
            if (body_seen < COUNT_MAX)
                body_seen++;
            flag = (body_seen > MAX_BODY_DEF);
            // bitwise LSB-first CRC update
            for (int k = 0; k < 8; k++)
            begin
                if (crc_acc[0] ^ b[k])
                    crc_acc = {1'b0, crc_acc[15:1]} ^ CRC_POLY;
                else
                    crc_acc = {1'b0, crc_acc[15:1]};
            end
            item = '{b, 1'b0, 1'b0, flag};
            pending_bytes.push_back(item);
            if (last)
            begin
                item = '{crc_acc[7:0], 1'b1, 1'b0, flag};
                pending_bytes.push_back(item);
                item = '{crc_acc[15:8], 1'b1, 1'b1, flag};
                pending_bytes.push_back(item);
                crc_acc   = CRC_INIT;
                body_seen = 0;
            end
        endfunction

        // Accepted wire byte: compare with the oldest prediction
        function void check_byte(wire_byte_t got);
            wire_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                if (mismatches < 10)
                    $display("ERROR: unexpected wire byte data=%02h crc=%0b end=%0b long=%0b",
                             got.data, got.is_crc, got.frame_end, got.too_long);
                mismatches++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got.data !== want.data || got.is_crc !== want.is_crc ||
                    got.frame_end !== want.frame_end || got.too_long !== want.too_long)
                begin
                    if (mismatches < 10)
                    begin
                        $display("ERROR: wire byte exp data=%02h crc=%0b end=%0b long=%0b",
                                 want.data, want.is_crc, want.frame_end, want.too_long);
                        $display("       got data=%02h crc=%0b end=%0b long=%0b",
                                 got.data, got.is_crc, got.frame_end, got.too_long);
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] body_byte
    logic       s_tlast = 1'b0;    // end_of_body
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] frame_byte
    logic [1:0] m_tuser;           // [0] is_crc, [1] too_long
    logic       m_tlast;           // frame_end

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req_count = 0;

    frame_scoreboard sb = new();

    modbus_rtu_frame_builder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Monitor: both handshakes sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_byte({m_tdata, m_tuser[0], m_tlast, m_tuser[1]});
            if (s_tvalid && s_tready)
                sb.note_body(s_tdata, s_tlast);
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int unsigned holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req_count != holds_served)
            begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one body byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Stimulus
    initial
    begin
        int unsigned sent;
        int unsigned len;
        int unsigned drain;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte bodies at both byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // read holding registers request: slave 1, fn 3, addr 0, count 10
        send_byte(8'h01, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0A, 1'b1);
        // alternating, single-bit-set and single-bit-clear patterns
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        // two-byte body
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_gap_pct = 87; recv_stall_pct <= 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct <= 87; end
                default: begin send_gap_pct = 10; recv_stall_pct <= 10; end
            endcase

            // long receiver hold-off while a frame keeps coming
            if (phase == 0)
            begin
                hold_req_count <= hold_req_count + 1;
                send_random_frame(24);
            end

            // one long body: crosses the limit, then the count saturates
            if (phase == 3)
                send_random_frame(COUNT_MAX + 2);

            sent = 0;
            while (sent < 16)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(13, 30);
                else
                    len = $urandom_range(1, 8);
                send_random_frame(len);
                sent += len;
            end
        end
        s_tvalid <= 1'b0;

        // wait for the output to drain
        drain = 0;
        while (sb.pending_bytes.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
            $display("All tests passed");
        else
        begin
            if (sb.pending_bytes.size() != 0)
                $display("ERROR: %0d expected wire bytes never arrived",
                         sb.pending_bytes.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mrfb_pkg.sv
src/mrfb_in_stage.sv
src/mrfb_framer.sv
src/modbus_rtu_frame_builder.sv
tb/tb_top.sv
